### rtl/bc3_pkg.sv
// ----------------------------------------------------------------------------
// BC3 texel decode package
// Shared types, code names and helper functions for the texel decoder.
// ----------------------------------------------------------------------------
package bc3_pkg;

   localparam logic [2:0] ACODE_E0   = 3'd0;
   localparam logic [2:0] ACODE_E1   = 3'd1;
   localparam logic [2:0] ACODE_ZERO = 3'd6;
   localparam logic [2:0] ACODE_FULL = 3'd7;

   localparam logic [1:0] CCODE_E0   = 2'd0;
   localparam logic [1:0] CCODE_E1   = 2'd1;
   localparam logic [1:0] CCODE_MID0 = 2'd2;
   localparam logic [1:0] CCODE_MID1 = 2'd3;

   // Reciprocal multipliers: floor(s/3) = (s*683)>>11 for s < 768,
   // floor(s/7) and floor(s/5) = (s*K)>>16 for s < 2048.
   localparam logic [9:0]  DIV3_MUL  = 10'd683;
   localparam logic [13:0] DIV7_MUL  = 14'd9363;
   localparam logic [13:0] DIV5_MUL  = 14'd13108;

   typedef enum logic [1:0] {
      ALPHA_PASS,
      ALPHA_DIV7,
      ALPHA_DIV5
   } alpha_mode_type;

   typedef struct packed {
      logic [7:0]       a0;
      logic [7:0]       a1;
      logic [2:0]       acode;
      logic [1:0]       ccode;
      logic [2:0][7:0]  e0;
      logic [2:0][7:0]  e1;
   } unpack_type;

   typedef struct packed {
      logic [10:0]      alpha_sum;
      alpha_mode_type   alpha_mode;
      logic [2:0][9:0]  color_sum;
      logic             color_div;
   } blend_type;

   typedef struct packed {
      logic [2:0][7:0]  rgb;
      logic [7:0]       alpha;
   } texel_type;

   // v*255/31 = 8v + floor(7v/31).
   function automatic logic [7:0] expand5(input logic [4:0] v);
      logic [2:0] f;
      begin
         if (v >= 5'd31) f = 3'd7;
         else if (v >= 5'd27) f = 3'd6;
         else if (v >= 5'd23) f = 3'd5;
         else if (v >= 5'd18) f = 3'd4;
         else if (v >= 5'd14) f = 3'd3;
         else if (v >= 5'd9) f = 3'd2;
         else if (v >= 5'd5) f = 3'd1;
         else f = 3'd0;
         return {v, 3'b000} + {5'b00000, f};
      end
   endfunction

   // v*255/63 = 4v + floor(v/21).
   function automatic logic [7:0] expand6(input logic [5:0] v);
      logic [1:0] f;
      begin
         if (v >= 6'd63) f = 2'd3;
         else if (v >= 6'd42) f = 2'd2;
         else if (v >= 6'd21) f = 2'd1;
         else f = 2'd0;
         return {v, 2'b00} + {6'b000000, f};
      end
   endfunction

endpackage

### rtl/bc3_texel_decode_unit.sv
// ----------------------------------------------------------------------------
// BC3 texel decode unit
// Decodes the RGBA value of one texel from a 16-byte BC3 block.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Payload
//  req_      in         req_valid/req_ready    alpha_block, colour_block, texel_index
//  rsp_      out        rsp_valid/rsp_ready    red, green, blue, alpha
//
//  A request passes through three register stages, unpack, blend and
//  reciprocal divide, on its way to a valid response, and a new request can be
//  accepted on every cycle while rsp_ready is high. Reset clears the
//  stage valid bits only. A stalled response holds its stage, and earlier
//  stages keep filling until each holds a request.
// ----------------------------------------------------------------------------
module bc3_texel_decode_unit
   import bc3_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_alpha_block,
   input  logic [63:0] req_colour_block,
   input  logic [3:0]  req_texel_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [7:0]  rsp_alpha
);

   logic       unpack_valid;
   logic       blend_ready;
   unpack_type unpack_data;
   logic       blend_valid;
   logic       divide_ready;
   blend_type  blend_data;
   texel_type  texel;

   bc3_unpack u_unpack (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_ready     (req_ready),
      .alpha_block  (req_alpha_block),
      .colour_block (req_colour_block),
      .texel_index  (req_texel_index),
      .out_valid    (unpack_valid),
      .out_ready    (blend_ready),
      .out_data     (unpack_data)
   );

   bc3_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (unpack_valid),
      .in_ready  (blend_ready),
      .in_data   (unpack_data),
      .out_valid (blend_valid),
      .out_ready (divide_ready),
      .out_data  (blend_data)
   );

   bc3_divide u_divide (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (blend_valid),
      .in_ready  (divide_ready),
      .in_data   (blend_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (texel)
   );

   assign rsp_red   = texel.rgb[0];
   assign rsp_green = texel.rgb[1];
   assign rsp_blue  = texel.rgb[2];
   assign rsp_alpha = texel.alpha;

   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("request side stalled while the response side is ready");

   a_unpack_hold: assert property (@(posedge clock) disable iff (reset)
      unpack_valid && !blend_ready |=> unpack_valid)
      else $error("unpack stage lost a request under stall");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      !blend_valid && !(rsp_valid && !rsp_ready) |=> !rsp_valid)
      else $error("response appeared without a request in the blend stage");

endmodule

### rtl/bc3_unpack.sv
// ----------------------------------------------------------------------------
// BC3 unpack stage
// Selects the texel's codes and expands the RGB565 endpoints to 8 bits.
// ----------------------------------------------------------------------------
module bc3_unpack
   import bc3_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [63:0] alpha_block,
   input  logic [63:0] colour_block,
   input  logic [3:0]  texel_index,
   output logic        out_valid,
   input  logic        out_ready,
   output unpack_type  out_data
);

   logic             valid_ff;
   unpack_type       data_ff;
   unpack_type       data_in;
   logic [15:0][2:0] acodes;
   logic [15:0][1:0] ccodes;
   logic [15:0]      c0;
   logic [15:0]      c1;

   assign acodes = alpha_block[63:16];
   assign ccodes = colour_block[63:32];
   assign c0     = colour_block[15:0];
   assign c1     = colour_block[31:16];

   always_comb begin
      data_in.a0    = alpha_block[7:0];
      data_in.a1    = alpha_block[15:8];
      data_in.acode = acodes[texel_index];
      data_in.ccode = ccodes[texel_index];
      data_in.e0[0] = expand5(c0[15:11]);
      data_in.e0[1] = expand6(c0[10:5]);
      data_in.e0[2] = expand5(c0[4:0]);
      data_in.e1[0] = expand5(c1[15:11]);
      data_in.e1[1] = expand6(c1[10:5]);
      data_in.e1[2] = expand5(c1[4:0]);
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

### rtl/bc3_blend.sv
// ----------------------------------------------------------------------------
// BC3 blend stage
// Forms the weighted endpoint sums for the alpha and color palettes.
// ----------------------------------------------------------------------------
module bc3_blend
   import bc3_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  unpack_type  in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output blend_type   out_data
);

   logic       valid_ff;
   blend_type  data_ff;
   blend_type  data_in;
   logic       eight_level;
   logic [2:0] step;
   logic [2:0] w0;
   logic [10:0] weighted;

   assign eight_level = in_data.a0 > in_data.a1;
   assign step        = in_data.acode - 3'd1;
   assign w0          = eight_level ? (3'd7 - step) : (3'd5 - step);
   assign weighted    = 11'(w0) * 11'(in_data.a0) + 11'(step) * 11'(in_data.a1);

   always_comb begin
      data_in.alpha_sum  = weighted;
      data_in.alpha_mode = eight_level ? ALPHA_DIV7 : ALPHA_DIV5;
      if (in_data.acode == ACODE_E0) begin
         data_in.alpha_sum  = {3'b000, in_data.a0};
         data_in.alpha_mode = ALPHA_PASS;
      end else if (in_data.acode == ACODE_E1) begin
         data_in.alpha_sum  = {3'b000, in_data.a1};
         data_in.alpha_mode = ALPHA_PASS;
      end else if (!eight_level && in_data.acode == ACODE_ZERO) begin
         data_in.alpha_sum  = 11'd0;
         data_in.alpha_mode = ALPHA_PASS;
      end else if (!eight_level && in_data.acode == ACODE_FULL) begin
         data_in.alpha_sum  = 11'd255;
         data_in.alpha_mode = ALPHA_PASS;
      end
   end

   always_comb begin
      data_in.color_div = 1'b0;
      for (int c = 0; c < 3; c++) begin
         case (in_data.ccode)
            CCODE_E0: data_in.color_sum[c] = {2'b00, in_data.e0[c]};
            CCODE_E1: data_in.color_sum[c] = {2'b00, in_data.e1[c]};
            CCODE_MID0: data_in.color_sum[c] = {1'b0, in_data.e0[c], 1'b0}
                                             + {2'b00, in_data.e1[c]};
            default: data_in.color_sum[c] = {2'b00, in_data.e0[c]}
                                          + {1'b0, in_data.e1[c], 1'b0};
         endcase
      end
      if (in_data.ccode == CCODE_MID0 || in_data.ccode == CCODE_MID1) begin
         data_in.color_div = 1'b1;
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

### rtl/bc3_divide.sv
// ----------------------------------------------------------------------------
// BC3 divide stage
// Divides the palette sums by 3, 5 or 7 through reciprocal multiplication.
// ----------------------------------------------------------------------------
module bc3_divide
   import bc3_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  blend_type   in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output texel_type   out_data
);

   logic        valid_ff;
   texel_type   data_ff;
   texel_type   data_in;
   logic [13:0] alpha_mul;
   logic [24:0] alpha_prod;
   logic [2:0][19:0] color_prod;

   always_comb begin
      case (in_data.alpha_mode)
         ALPHA_DIV7: alpha_mul = DIV7_MUL;
         default: alpha_mul = DIV5_MUL;
      endcase
   end

   assign alpha_prod = 25'(in_data.alpha_sum) * 25'(alpha_mul);

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         color_prod[c] = 20'(in_data.color_sum[c]) * 20'(DIV3_MUL);
         data_in.rgb[c] = in_data.color_div ? color_prod[c][18:11]
                                            : in_data.color_sum[c][7:0];
      end
      data_in.alpha = (in_data.alpha_mode == ALPHA_PASS) ? in_data.alpha_sum[7:0]
                                                         : alpha_prod[23:16];
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule
